// ----- rtl/scr_pkg.sv -----
// Shared constants and types for the substring run match scorer.
// Depends on nothing; every other file of the block refers to it by scoped names.
package scr_pkg;

    // Mask geometry: up to MASK_LEN characters held in four 64-bit words.
    localparam int MASK_LEN       = 16;
    localparam int CHAR_W         = 16;
    localparam int CHARS_PER_WORD = 4;
    localparam int NUM_WORDS      = 4;
    localparam int WORD_W         = CHAR_W * CHARS_PER_WORD;

    // Run length, mask length and total widths.
    localparam int LEN_W          = 5;
    localparam int TOTAL_W        = 16;
    localparam int MIN_SCORED_RUN = 3;

    // Configuration port geometry: 64-bit registers at byte address 8*i.
    localparam int DATA_W  = 64;
    localparam int ADDR_W  = 6;
    localparam int INDEX_W = 3;
    localparam int INDEX_LSB = 3;

    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [MASK_LEN-1:0] pos_set_t;
    typedef logic [LEN_W-1:0]    run_len_t;
    typedef logic [TOTAL_W-1:0]  total_t;

    // Register indexes in address order.
    typedef enum logic [INDEX_W-1:0] {
        REG_MASK_A      = 3'd0,
        REG_MASK_B      = 3'd1,
        REG_MASK_C      = 3'd2,
        REG_MASK_D      = 3'd3,
        REG_MASK_LENGTH = 3'd4
    } cfg_index_t;

endpackage

// ----- rtl/scr_item_if.sv -----
// Input channel of the scorer: one text character with its flags per item.
// Depends on scr_pkg for the character type.
interface scr_item_if;
    logic           valid;
    logic           ready;
    scr_pkg::char_t symbol;
    logic           is_last;
    logic           clear_before;

    modport source (output valid, output symbol, output is_last, output clear_before,
                    input ready);
    modport sink   (input valid, input symbol, input is_last, input clear_before,
                    output ready);
endinterface

// ----- rtl/scr_result_if.sv -----
// Result channel of the scorer: one matched total per item.
// Depends on scr_pkg for the total type.
interface scr_result_if;
    logic            valid;
    logic            ready;
    scr_pkg::total_t matched_total;

    modport source (output valid, output matched_total, input ready);
    modport sink   (input valid, input matched_total, output ready);
endinterface

// ----- rtl/substring_run_match_scorer.sv -----
// Top level of the substring run match scorer: config registers, input
// register, shift-and run tracker and result register.
// Depends on scr_pkg, scr_item_if and scr_result_if.
//
// Usage:
// - in_ch carries one text character per item with is_last and clear_before.
//   out_ch carries one matched_total item for every input item with is_last.
// - Mask characters and mask length are written over the APB-style port
//   (64-bit registers at byte address 8*i, pready always high) while idle.
// - An accepted item is held in the input register; from there it is compared
//   against all mask characters in parallel, the run state is updated and,
//   for a last character, the result register is loaded. A result therefore
//   passes through the input register and the result register before it can
//   be taken.
// - Throughput is one item per clock, unless stalled as below; the limit is the
//   run state update (compare, shift-and, saturating add) feeding back on itself.
// - When the receiver stalls, the result register holds its item and further
//   characters keep flowing until a second last character reaches the input
//   register; only then does in_ch.ready drop.
// - Reset clears the mask registers, the run state, the total and both valid
//   flags. clear_before clears the run and total but never the registers.
module substring_run_match_scorer (
    input  logic                        clk,
    input  logic                        rst_n,
    scr_item_if.sink                    in_ch,
    scr_result_if.source                out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scr_pkg::ADDR_W-1:0]  paddr,
    input  logic [scr_pkg::DATA_W-1:0]  pwdata,
    output logic [scr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    // Configuration registers.
    logic [scr_pkg::NUM_WORDS-1:0][scr_pkg::WORD_W-1:0] mask_word_reg;
    scr_pkg::run_len_t                                   mask_length_reg;
    logic [scr_pkg::NUM_WORDS*scr_pkg::WORD_W-1:0]       mask_flat;
    scr_pkg::cfg_index_t                                 cfg_index;
    logic                                                cfg_write;

    // Input register.
    logic           s1_valid_reg;
    scr_pkg::char_t s1_symbol_reg;
    logic           s1_last_reg;
    logic           s1_clear_reg;
    logic           s1_advance;
    logic           in_take;

    // Run state.
    scr_pkg::pos_set_t run_set_reg;
    scr_pkg::pos_set_t run_set_next;
    scr_pkg::run_len_t run_len_reg;
    scr_pkg::run_len_t run_len_next;
    scr_pkg::total_t   total_reg;
    scr_pkg::total_t   total_next;

    // Result register.
    logic            out_valid_reg;
    scr_pkg::total_t out_total_reg;

    // Working values of the run update.
    scr_pkg::pos_set_t hits;
    scr_pkg::pos_set_t set_base;
    scr_pkg::pos_set_t set_ext;
    scr_pkg::run_len_t len_base;
    scr_pkg::run_len_t len_ext;
    scr_pkg::run_len_t add_len;
    scr_pkg::total_t   total_base;
    logic [scr_pkg::TOTAL_W:0] total_sum;

    assign pready    = 1'b1;
    assign cfg_index = scr_pkg::cfg_index_t'(paddr[scr_pkg::INDEX_LSB +: scr_pkg::INDEX_W]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign mask_flat = mask_word_reg;

    // Register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_word_reg   <= '0;
            mask_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                scr_pkg::REG_MASK_A:      mask_word_reg[0] <= pwdata;
                scr_pkg::REG_MASK_B:      mask_word_reg[1] <= pwdata;
                scr_pkg::REG_MASK_C:      mask_word_reg[2] <= pwdata;
                scr_pkg::REG_MASK_D:      mask_word_reg[3] <= pwdata;
                scr_pkg::REG_MASK_LENGTH: mask_length_reg  <= pwdata[scr_pkg::LEN_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Register read; addresses beyond the list read as zero.
    always_comb
    begin
        unique case (cfg_index)
            scr_pkg::REG_MASK_A:      prdata = mask_word_reg[0];
            scr_pkg::REG_MASK_B:      prdata = mask_word_reg[1];
            scr_pkg::REG_MASK_C:      prdata = mask_word_reg[2];
            scr_pkg::REG_MASK_D:      prdata = mask_word_reg[3];
            scr_pkg::REG_MASK_LENGTH: prdata = {{(scr_pkg::DATA_W-scr_pkg::LEN_W){1'b0}},
                                                mask_length_reg};
            default:                  prdata = '0;
        endcase
    end

    // The input register moves on unless it holds a last character and the
    // result register is still occupied by an untaken item.
    assign s1_advance  = !(s1_last_reg && out_valid_reg && !out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_symbol_reg <= in_ch.symbol;
            s1_last_reg   <= in_ch.is_last;
            s1_clear_reg  <= in_ch.clear_before;
        end
    end

    // Parallel compare against every mask position below the mask length.
    always_comb
    begin
        for (int i = 0; i < scr_pkg::MASK_LEN; i++)
        begin
            hits[i] = (mask_flat[i*scr_pkg::CHAR_W +: scr_pkg::CHAR_W] == s1_symbol_reg)
                      && (scr_pkg::LEN_W'(i) < mask_length_reg);
        end
    end

    // Shift-and run update with at most one run closed per character.
    always_comb
    begin
        set_base   = s1_clear_reg ? '0 : run_set_reg;
        len_base   = s1_clear_reg ? '0 : run_len_reg;
        total_base = s1_clear_reg ? '0 : total_reg;
        set_ext    = hits & (set_base << 1);
        len_ext    = len_base + scr_pkg::LEN_W'(1);

        priority if (hits == '0)
        begin
            // A miss closes the live run.
            add_len      = len_base;
            run_set_next = '0;
            run_len_next = '0;
        end
        else if (set_base == '0)
        begin
            // A hit with no live run starts one; too short to score on its own.
            add_len      = '0;
            run_set_next = s1_last_reg ? '0 : hits;
            run_len_next = s1_last_reg ? '0 : scr_pkg::LEN_W'(1);
        end
        else if (set_ext == '0)
        begin
            // A breaking character closes the run without starting a new one.
            add_len      = len_base;
            run_set_next = '0;
            run_len_next = '0;
        end
        else
        begin
            // The run grows; a last character flushes it at once.
            add_len      = s1_last_reg ? len_ext : '0;
            run_set_next = s1_last_reg ? '0 : set_ext;
            run_len_next = s1_last_reg ? '0 : len_ext;
        end

        // Saturating add of runs long enough to score.
        total_sum = {1'b0, total_base} + (scr_pkg::TOTAL_W+1)'(add_len);
        if (add_len < scr_pkg::LEN_W'(scr_pkg::MIN_SCORED_RUN))
        begin
            total_next = total_base;
        end
        else if (total_sum[scr_pkg::TOTAL_W])
        begin
            total_next = '1;
        end
        else
        begin
            total_next = total_sum[scr_pkg::TOTAL_W-1:0];
        end
    end

    // Run state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_set_reg <= '0;
            run_len_reg <= '0;
            total_reg   <= '0;
        end
        else if (s1_valid_reg && s1_advance)
        begin
            run_set_reg <= run_set_next;
            run_len_reg <= run_len_next;
            total_reg   <= total_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_advance && s1_last_reg)
        begin
            out_total_reg <= total_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.matched_total = out_total_reg;

`ifndef SYNTHESIS
    // A live run always has both an end position and a nonzero length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (run_set_reg == '0) == (run_len_reg == '0))
        else $error("run set and run length disagree");

    // A run can never be longer than the mask.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_len_reg <= scr_pkg::LEN_W'(scr_pkg::MASK_LEN))
        else $error("run length exceeds mask length");

    // A new result only follows a last character leaving the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result appeared without a last character");

    // Input stalls only while a last character waits behind an untaken result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (s1_valid_reg && out_valid_reg && s1_last_reg))
        else $error("input stalled without a blocked result");
`endif

endmodule
